// ----- design/dsp_pkg.sv -----
// shared types and constants of the dataflash stream programmer
package dsp_pkg;

	typedef enum logic [2:0] {
		ACT_CMD     = 3'd0,
		ACT_DATA    = 3'd1,
		ACT_RELEASE = 3'd2,
		ACT_WAIT    = 3'd3,
		ACT_BWAIT   = 3'd4
	} action_t;

	localparam logic [15:0] OP_BUF1_WRITE = 16'h8400;
	localparam logic [15:0] OP_BUF1_PROG  = 16'h8300;
	localparam logic [15:0] OP_BUF2_WRITE = 16'h8700;
	localparam logic [15:0] OP_BUF2_PROG  = 16'h8600;

	localparam logic [7:0] RST_BUFFER_SIZE = 8'd132;
	localparam logic [4:0] RST_PAGE_SHIFT  = 5'd9;
	localparam logic [7:0] MAX_PAGE_SHIFT  = 8'd31;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	// one accepted data byte, classified for the back end
	typedef struct packed {
		logic        bwait;
		logic        open;
		logic        commit;
		logic [15:0] open_word;
		logic [15:0] prog_word;
		logic [15:0] addr_word;
		logic [7:0]  data_byte;
	} job_t;

endpackage

// ----- design/dsp_if.sv -----
// stream channel interfaces: input bytes and output actions
interface dsp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

interface dsp_act_if;
	logic              valid;
	logic              ready;
	dsp_pkg::action_t  action;
	logic [15:0]       spi_word;
	logic              last;

	modport source (output valid, output action, output spi_word, output last, input ready);
	modport sink (input valid, input action, input spi_word, input last, output ready);
endinterface

// ----- design/dsp_front.sv -----
// front end: header parsing, page addressing and byte classification
module dsp_front (
	input  logic          clk,
	input  logic          arst_n,
	dsp_byte_if.sink      stream,
	output logic          push_valid,
	input  logic          push_ready,
	output dsp_pkg::job_t push_data
);
	import dsp_pkg::*;

	typedef enum logic [2:0] {
		PH_HEADER = 3'd0,
		PH_FILL1  = 3'd1,
		PH_OPEN2  = 3'd2,
		PH_FILL2  = 3'd3,
		PH_OPEN1  = 3'd4
	} phase_t;

	localparam logic [7:0] HDR_PAGE_BYTES = 8'd2;
	localparam logic [7:0] HDR_SIZE_IDX   = 8'd3;
	localparam logic [7:0] HDR_BYTES      = 8'd4;

	phase_t      phase_q, phase_d;
	logic [7:0]  count_q, count_d;
	logic [7:0]  size_q, size_d;
	logic [4:0]  shift_q, shift_d;
	logic [31:0] start_q, start_d;
	logic [31:0] page_q, page_d;
	logic [31:0] addr_q, addr_d;

	logic        accept;
	logic [7:0]  b;
	logic [7:0]  limit;
	logic [31:0] base_page;
	logic [31:0] new_addr;
	logic        use_new;
	logic [7:0]  cur_ahb;
	logic        has_job;
	logic        do_fill;
	logic [7:0]  fill_cnt;
	logic [15:0] fill_prog;
	logic [15:0] open_op;
	phase_t      fill_stay;
	phase_t      fill_next;
	job_t        job;

	assign stream.ready = push_ready;
	assign accept       = stream.valid && push_ready;
	assign b            = stream.data_byte;

	// a size of zero behaves as one
	assign limit     = (size_q == 8'd0) ? 8'd0 : size_q - 8'd1;
	assign base_page = (phase_q == PH_HEADER) ? start_q : page_q + 32'd1;
	assign new_addr  = base_page << shift_q;

	always_comb begin
		phase_d   = phase_q;
		count_d   = count_q;
		size_d    = size_q;
		shift_d   = shift_q;
		start_d   = start_q;
		page_d    = page_q;
		addr_d    = addr_q;
		use_new   = 1'b0;
		has_job   = 1'b0;
		do_fill   = 1'b0;
		fill_cnt  = count_q;
		fill_prog = OP_BUF1_PROG;
		fill_stay = PH_FILL1;
		fill_next = PH_OPEN2;
		open_op   = OP_BUF1_WRITE;
		job       = '0;

		unique case (phase_q)
			PH_HEADER: begin
				if (count_q < HDR_PAGE_BYTES) begin
					start_d = {start_q[15:0], 16'h0000} + {24'h000000, b};
					count_d = count_q + 8'd1;
				end else if (count_q < HDR_SIZE_IDX) begin
					size_d  = b;
					count_d = count_q + 8'd1;
				end else if (count_q < HDR_BYTES) begin
					shift_d = (b > MAX_PAGE_SHIFT) ? MAX_PAGE_SHIFT[4:0] : b[4:0];
					count_d = count_q + 8'd1;
				end else begin
					has_job   = 1'b1;
					job.bwait = 1'b1;
					job.open  = 1'b1;
					open_op   = OP_BUF1_WRITE;
					page_d    = start_q;
					addr_d    = new_addr;
					use_new   = 1'b1;
					do_fill   = 1'b1;
					fill_cnt  = 8'd0;
				end
			end
			PH_FILL1: begin
				has_job = 1'b1;
				do_fill = 1'b1;
			end
			PH_OPEN2: begin
				has_job   = 1'b1;
				job.open  = 1'b1;
				open_op   = OP_BUF2_WRITE;
				page_d    = page_q + 32'd1;
				addr_d    = new_addr;
				use_new   = 1'b1;
				do_fill   = 1'b1;
				fill_cnt  = 8'd0;
				fill_prog = OP_BUF2_PROG;
				fill_stay = PH_FILL2;
				fill_next = PH_OPEN1;
			end
			PH_FILL2: begin
				has_job   = 1'b1;
				do_fill   = 1'b1;
				fill_prog = OP_BUF2_PROG;
				fill_stay = PH_FILL2;
				fill_next = PH_OPEN1;
			end
			PH_OPEN1: begin
				has_job  = 1'b1;
				job.open = 1'b1;
				open_op  = OP_BUF1_WRITE;
				page_d   = page_q + 32'd1;
				addr_d   = new_addr;
				use_new  = 1'b1;
				count_d  = 8'd1;
				phase_d  = PH_FILL1;
			end
			default: begin
				has_job = 1'b0;
			end
		endcase

		// buffer fill: count the byte, or commit when the buffer is full
		if (do_fill) begin
			if (fill_cnt < limit) begin
				count_d = fill_cnt + 8'd1;
				phase_d = fill_stay;
			end else begin
				job.commit = 1'b1;
				count_d    = fill_cnt;
				phase_d    = fill_next;
			end
		end

		cur_ahb       = use_new ? new_addr[23:16] : addr_q[23:16];
		job.addr_word = use_new ? new_addr[15:0] : addr_q[15:0];
		job.open_word = open_op + {8'h00, cur_ahb};
		job.prog_word = fill_prog + {8'h00, cur_ahb};
		job.data_byte = b;
	end

	assign push_valid = accept && has_job;
	assign push_data  = job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			count_q <= 8'd0;
			size_q  <= RST_BUFFER_SIZE;
			shift_q <= RST_PAGE_SHIFT;
			start_q <= 32'd0;
			page_q  <= 32'd0;
			addr_q  <= 32'd0;
		end else if (accept) begin
			phase_q <= phase_d;
			count_q <= count_d;
			size_q  <= size_d;
			shift_q <= shift_d;
			start_q <= start_d;
			page_q  <= page_d;
			addr_q  <= addr_d;
		end
	end

	a_header_no_job: assert property (@(posedge clk) disable iff (!arst_n)
		(push_valid && phase_q == PH_HEADER) |-> count_q >= HDR_BYTES)
		else $error("header byte produced a job");

	a_open2_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && phase_q == PH_OPEN2) |=> (phase_q == PH_FILL2 || phase_q == PH_OPEN1))
		else $error("buffer 2 open did not move to fill or commit");

	a_open1_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && phase_q == PH_OPEN1) |=> (phase_q == PH_FILL1 && count_q == 8'd1))
		else $error("buffer 1 reopen lost its byte count");

endmodule

// ----- design/dsp_fifo.sv -----
// short job queue between front and back end
module dsp_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  dsp_pkg::job_t push_data,
	output logic          pop_valid,
	input  logic          pop_ready,
	output dsp_pkg::job_t pop_data
);
	import dsp_pkg::*;

	localparam logic [FIFO_AW-1:0] LAST_PTR = FIFO_AW'(FIFO_DEPTH - 1);
	localparam logic [FIFO_AW:0]   FULL_CNT = (FIFO_AW + 1)'(FIFO_DEPTH);
	localparam logic [FIFO_AW-1:0] PTR_ONE  = FIFO_AW'(1);
	localparam logic [FIFO_AW:0]   CNT_ONE  = (FIFO_AW + 1)'(1);

	job_t              mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FIFO_AW:0]   count_q;
	logic               push;
	logic               pop;

	assign push_ready = (count_q != FULL_CNT);
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_ONE;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_ONE;
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_ONE;
			end else if (pop && !push) begin
				count_q <= count_q - CNT_ONE;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("queue fill count beyond depth");

	a_push_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + CNT_ONE)
		else $error("push without pop did not raise the fill count");

endmodule

// ----- design/dsp_back.sv -----
// back end: expands each job into its ordered spi actions
module dsp_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          pop_valid,
	output logic          pop_ready,
	input  dsp_pkg::job_t pop_data,
	dsp_act_if.source     actions
);
	import dsp_pkg::*;

	typedef enum logic [3:0] {
		ST_BWAIT     = 4'd0,
		ST_OPEN_CMD  = 4'd1,
		ST_OPEN_ADDR = 4'd2,
		ST_DATA      = 4'd3,
		ST_REL1      = 4'd4,
		ST_WAIT      = 4'd5,
		ST_PROG_CMD  = 4'd6,
		ST_PROG_ADDR = 4'd7,
		ST_REL2      = 4'd8
	} step_t;

	step_t step_q, step_nxt, step_first;
	job_t  cur_q;
	logic  busy_q;
	logic  advance;
	logic  final_step;
	logic  load;

	assign advance    = busy_q && actions.ready;
	assign final_step = (step_q == ST_DATA && !cur_q.commit) || (step_q == ST_REL2);
	assign load       = !busy_q || (advance && final_step);
	assign pop_ready  = load;

	always_comb begin
		if (pop_data.bwait) begin
			step_first = ST_BWAIT;
		end else if (pop_data.open) begin
			step_first = ST_OPEN_CMD;
		end else begin
			step_first = ST_DATA;
		end
	end

	always_comb begin
		unique case (step_q)
			ST_BWAIT:     step_nxt = ST_OPEN_CMD;
			ST_OPEN_CMD:  step_nxt = ST_OPEN_ADDR;
			ST_OPEN_ADDR: step_nxt = ST_DATA;
			ST_DATA:      step_nxt = ST_REL1;
			ST_REL1:      step_nxt = ST_WAIT;
			ST_WAIT:      step_nxt = ST_PROG_CMD;
			ST_PROG_CMD:  step_nxt = ST_PROG_ADDR;
			ST_PROG_ADDR: step_nxt = ST_REL2;
			ST_REL2:      step_nxt = ST_REL2;
			default:      step_nxt = ST_REL2;
		endcase
	end

	always_comb begin
		actions.spi_word = 16'h0000;
		unique case (step_q)
			ST_BWAIT:     actions.action = ACT_BWAIT;
			ST_OPEN_CMD: begin
				actions.action   = ACT_CMD;
				actions.spi_word = cur_q.open_word;
			end
			ST_OPEN_ADDR: begin
				actions.action   = ACT_DATA;
				actions.spi_word = cur_q.addr_word;
			end
			ST_DATA: begin
				actions.action   = ACT_DATA;
				actions.spi_word = {8'h00, cur_q.data_byte};
			end
			ST_REL1:      actions.action = ACT_RELEASE;
			ST_WAIT:      actions.action = ACT_WAIT;
			ST_PROG_CMD: begin
				actions.action   = ACT_CMD;
				actions.spi_word = cur_q.prog_word;
			end
			ST_PROG_ADDR: begin
				actions.action   = ACT_DATA;
				actions.spi_word = cur_q.addr_word;
			end
			ST_REL2:      actions.action = ACT_RELEASE;
			default:      actions.action = ACT_RELEASE;
		endcase
	end

	assign actions.valid = busy_q;
	assign actions.last  = final_step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= ST_DATA;
			cur_q  <= '0;
		end else if (load) begin
			busy_q <= pop_valid;
			if (pop_valid) begin
				cur_q  <= pop_data;
				step_q <= step_first;
			end
		end else if (advance) begin
			step_q <= step_nxt;
		end
	end

	a_bwait_opens: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && step_q == ST_BWAIT) |-> cur_q.open)
		else $error("bounded wait on a job that opens no buffer");

	a_commit_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && (step_q == ST_REL1 || step_q == ST_WAIT || step_q == ST_REL2)) |-> cur_q.commit)
		else $error("commit sequence on a job without commit");

	a_drain_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && final_step && !pop_valid) |=> !busy_q)
		else $error("back end stayed busy with no job left");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !actions.ready) |=> (busy_q && $stable(step_q)))
		else $error("action changed while stalled");

endmodule

// ----- design/dataflash_stream_programmer.sv -----
// top level: dataflash stream programmer built from front end, job queue and back end
// a byte's job is registered into the job queue, then loaded into the back end sequencer
// throughput: one byte a cycle while the four-entry job queue has room; the back end sequencer
// gives one action a cycle while the action sink is ready; a byte causes 1 up to 9 actions
// header bytes cause no action
// reset: asynchronous, clears queue and sequencer, header phase, buffer size 132, page shift 9
module dataflash_stream_programmer (
	input  logic      clk,
	input  logic      arst_n,
	dsp_byte_if.sink  stream,
	dsp_act_if.source actions
);
	import dsp_pkg::*;

	logic push_valid;
	logic push_ready;
	job_t push_data;
	logic pop_valid;
	logic pop_ready;
	job_t pop_data;

	dsp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.stream     (stream),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	dsp_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	dsp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.actions   (actions)
	);

endmodule
